/* rtl/ifmt_pkg.sv */
`timescale 1ns / 1ps
// package: conversion codes, character constants and shared types of the field formatter
package ifmt_pkg;

    // parameter defaults
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_PREC_DEF   = 60;
    localparam int MAX_WIDTH_DEF  = 63;

    // port and field widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;
    localparam int VAL_W      = 32;
    localparam int FLD_W      = 6;
    localparam int CNT_W      = 7;

    // conversion codes
    typedef enum logic [2:0] {
        CMD_SDEC = 3'd0,
        CMD_UDEC = 3'd1,
        CMD_OCT  = 3'd2,
        CMD_HEXL = 3'd3,
        CMD_HEXU = 3'd4,
        CMD_PTR  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    // ascii characters
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    // decoded conversion that travels with the value
    typedef struct packed {
        radix_t             radix;
        logic               upper;
        logic               has_sign;
        logic [7:0]         sign_ch;
        logic [1:0]         pre_len;
        logic [FLD_W-1:0]   wid;
        logic [FLD_W-1:0]   mind;
        logic               left;
        logic               zfill;
    } fmt_t;

    // one digit to its ascii character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] ch;
        if (d > 4'd9)
            ch = 8'(d) - 8'd10 + (upper ? CH_UPPER_A : CH_LOWER_A);
        else
            ch = 8'(d) + CH_ZERO;
        return ch;
    endfunction

endpackage

/* rtl/integer_field_formatter_unit.sv */
`timescale 1ns / 1ps
// top level: integer conversion formatter, decode, binary to bcd pipeline and character emitter
//
// Each input item is one parsed integer conversion; the block answers with the
// formatted ascii field, one character per output item, tlast on the final one.
// Unknown conversion codes (6, 7) are taken and give no output. An item passes
// an input decode stage, (VALUE_BITS+3)/4 binary-to-bcd stages of four bits each,
// a digit count stage and a padding stage before it reaches the emitter, which gives
// one character per cycle while m_axis_tready is high. A field is max(width,
// content length) characters, 1 to 63, on the single character port, which sets
// the sustained rate; the pipeline in front keeps later items moving while a
// field is sent.
module integer_field_formatter_unit #(
    parameter int VALUE_BITS    = ifmt_pkg::VALUE_BITS_DEF,
    parameter int MAX_PRECISION = ifmt_pkg::MAX_PREC_DEF,
    parameter int MAX_WIDTH     = ifmt_pkg::MAX_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cmd, value, width, has_precision, precision, left_adjust, alt_form,
    // plus_flag, space_flag, zero_flag, three unused bits
    input  logic [ifmt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_char
    output logic [ifmt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import ifmt_pkg::*;

    localparam int NS    = (VALUE_BITS + 3) / 4;
    localparam int MW    = 4 * NS;
    localparam int NDMAX = (VALUE_BITS + 2) / 3;
    localparam int DIW   = $clog2(NDMAX);
    localparam int BCD_W = 4 * NDMAX;

    // input fields
    cmd_t             in_cmd;
    logic [VAL_W-1:0] in_value;
    logic [FLD_W-1:0] in_width;
    logic             in_has_prec;
    logic [FLD_W-1:0] in_prec;
    logic             in_left;
    logic             in_alt;
    logic             in_plus;
    logic             in_space;
    logic             in_zero;

    // decode stage signals
    logic [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  in_neg;
    logic                  in_ok;
    logic [FLD_W-1:0]      in_prec_c;
    fmt_t                  fmt_next;
    logic [MW-1:0]         mag_next;

    // front pipeline: decode stage and bcd stages
    logic [NS:0]      vld_reg;
    fmt_t             fmt_reg [NS+1];
    logic [MW-1:0]    mag_reg [NS+1];
    logic [BCD_W-1:0] bcd_reg [NS];
    logic [BCD_W-1:0] dab_next [NS];
    logic [NS:0]      en;

    // digit count stage
    logic                         a_vld_reg;
    logic                         a_en;
    fmt_t                         a_fmt_reg;
    logic [NDMAX-1:0][3:0]        a_dig_reg;
    logic [NDMAX-1:0][3:0]        a_dig_next;
    logic [FLD_W-1:0]             a_ndig_reg;
    logic [FLD_W-1:0]             a_ndig_next;

    // padding stage
    logic                  b_vld_reg;
    logic                  b_en;
    fmt_t                  b_fmt_reg;
    logic [NDMAX-1:0][3:0] b_dig_reg;
    logic [FLD_W-1:0]      b_ndig_reg;
    logic [FLD_W-1:0]      b_pad_reg;
    logic [FLD_W-1:0]      b_pad_next;
    logic [CNT_W-1:0]      b_dlen;

    // emitter
    logic                  e_busy_reg;
    logic [CNT_W-1:0]      e_pos_reg;
    logic [CNT_W-1:0]      e_lead_end_reg;
    logic [CNT_W-1:0]      e_sign_end_reg;
    logic [CNT_W-1:0]      e_pre_end_reg;
    logic [CNT_W-1:0]      e_zero_end_reg;
    logic [CNT_W-1:0]      e_dig_end_reg;
    logic [CNT_W-1:0]      e_last_reg;
    logic [7:0]            e_sign_ch_reg;
    logic                  e_upper_reg;
    logic [NDMAX-1:0][3:0] e_dig_reg;
    logic [CNT_W-1:0]      e_lead_end_next;
    logic [CNT_W-1:0]      e_sign_end_next;
    logic [CNT_W-1:0]      e_pre_end_next;
    logic [CNT_W-1:0]      e_zero_end_next;
    logic [CNT_W-1:0]      e_dig_end_next;
    logic [CNT_W-1:0]      e_last_next;
    logic                  e_at_last;
    logic                  emit_take;
    logic [CNT_W-1:0]      e_idx;

    // unpack input item
    assign in_cmd      = cmd_t'(s_axis_tdata[2:0]);
    assign in_value    = s_axis_tdata[34:3];
    assign in_width    = s_axis_tdata[40:35];
    assign in_has_prec = s_axis_tdata[41];
    assign in_prec     = s_axis_tdata[47:42];
    assign in_left     = s_axis_tdata[48];
    assign in_alt      = s_axis_tdata[49];
    assign in_plus     = s_axis_tdata[50];
    assign in_space    = s_axis_tdata[51];
    assign in_zero     = s_axis_tdata[52];

    // decode conversion, sign and magnitude
    always_comb
    begin
        in_val = '0;
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (i < VAL_W)
                in_val[i] = in_value[i];
        end
        in_neg   = (in_cmd == CMD_SDEC) && in_val[VALUE_BITS-1];
        in_mag   = in_neg ? VALUE_BITS'(~in_val + 1'b1) : in_val;
        mag_next = MW'(in_mag);
        in_ok    = s_axis_tvalid && (in_cmd <= CMD_PTR);

        case (in_cmd)
            CMD_OCT:                    fmt_next.radix = RADIX_OCT;
            CMD_HEXL, CMD_HEXU, CMD_PTR: fmt_next.radix = RADIX_HEX;
            default:                    fmt_next.radix = RADIX_DEC;
        endcase
        fmt_next.upper    = (in_cmd == CMD_HEXU);
        fmt_next.has_sign = (in_cmd == CMD_SDEC) && (in_neg || in_plus || in_space);
        fmt_next.sign_ch  = in_neg ? CH_MINUS : (in_plus ? CH_PLUS : CH_SPACE);
        fmt_next.pre_len  = 2'd0;
        if ((in_alt || in_cmd == CMD_PTR) && in_val != '0)
        begin
            if (fmt_next.radix == RADIX_OCT)
                fmt_next.pre_len = 2'd1;
            else if (fmt_next.radix == RADIX_HEX)
                fmt_next.pre_len = 2'd2;
        end
        fmt_next.wid = (in_width > FLD_W'(MAX_WIDTH)) ? FLD_W'(MAX_WIDTH) : in_width;
        in_prec_c    = (in_prec > FLD_W'(MAX_PRECISION)) ? FLD_W'(MAX_PRECISION) : in_prec;
        if (in_has_prec && in_prec_c != '0)
            fmt_next.mind = in_prec_c;
        else
            fmt_next.mind = FLD_W'(1);
        fmt_next.left  = in_left;
        fmt_next.zfill = !in_left && in_zero && !in_has_prec;
    end

    // stall chain, from the emitter back to the input
    assign e_at_last     = (e_pos_reg == e_last_reg);
    assign emit_take     = !e_busy_reg || (m_axis_tready && e_at_last);
    assign b_en          = !b_vld_reg || emit_take;
    assign a_en          = !a_vld_reg || b_en;
    assign s_axis_tready = en[0];

    always_comb
    begin
        en[NS] = !vld_reg[NS] || a_en;
        for (int i = NS - 1; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    // binary to bcd, four bits of the magnitude per stage
    always_comb
    begin
        logic [BCD_W-1:0] acc;
        logic [3:0]       nib;
        for (int i = 1; i <= NS; i++)
        begin
            if (i == 1)
                acc = '0;
            else
                acc = bcd_reg[i-2];
            nib = mag_reg[i-1][MW-1-4*(i-1) -: 4];
            for (int b = 3; b >= 0; b--)
            begin
                for (int d = 0; d < NDMAX; d++)
                begin
                    if (acc[4*d +: 4] >= 4'd5)
                        acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
                acc = {acc[BCD_W-2:0], nib[b]};
            end
            dab_next[i-1] = acc;
        end
    end

    // front pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= in_ok;
            for (int i = 1; i <= NS; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // front pipeline payload
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fmt_reg[0] <= fmt_next;
            mag_reg[0] <= mag_next;
        end
        for (int i = 1; i <= NS; i++)
        begin
            if (en[i])
            begin
                fmt_reg[i]   <= fmt_reg[i-1];
                mag_reg[i]   <= mag_reg[i-1];
                bcd_reg[i-1] <= dab_next[i-1];
            end
        end
    end

    // select digits by radix and count them
    always_comb
    begin
        logic [3:0]       oct;
        logic [3:0]       hex;
        logic [FLD_W-1:0] sig;
        sig = '0;
        for (int j = 0; j < NDMAX; j++)
        begin
            oct = '0;
            hex = '0;
            for (int b = 0; b < 3; b++)
            begin
                if (3 * j + b < MW)
                    oct[b] = mag_reg[NS][3*j+b];
            end
            for (int b = 0; b < 4; b++)
            begin
                if (4 * j + b < MW)
                    hex[b] = mag_reg[NS][4*j+b];
            end
            case (fmt_reg[NS].radix)
                RADIX_OCT: a_dig_next[j] = oct;
                RADIX_HEX: a_dig_next[j] = hex;
                default:   a_dig_next[j] = bcd_reg[NS-1][4*j +: 4];
            endcase
            if (a_dig_next[j] != 4'd0)
                sig = FLD_W'(j + 1);
        end
        a_ndig_next = (sig > fmt_reg[NS].mind) ? sig : fmt_reg[NS].mind;
    end

    // content length and padding
    always_comb
    begin
        b_dlen = CNT_W'(a_ndig_reg) + CNT_W'(a_fmt_reg.has_sign) + CNT_W'(a_fmt_reg.pre_len);
        if (CNT_W'(a_fmt_reg.wid) > b_dlen)
            b_pad_next = FLD_W'(CNT_W'(a_fmt_reg.wid) - b_dlen);
        else
            b_pad_next = '0;
    end

    // count and padding stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
                a_vld_reg <= vld_reg[NS];
            if (b_en)
                b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_fmt_reg  <= fmt_reg[NS];
            a_dig_reg  <= a_dig_next;
            a_ndig_reg <= a_ndig_next;
        end
        if (b_en)
        begin
            b_fmt_reg  <= a_fmt_reg;
            b_dig_reg  <= a_dig_reg;
            b_ndig_reg <= a_ndig_reg;
            b_pad_reg  <= b_pad_next;
        end
    end

    // segment boundaries of the field
    always_comb
    begin
        logic [CNT_W-1:0] pad;
        pad = CNT_W'(b_pad_reg);
        e_lead_end_next = (!b_fmt_reg.left && !b_fmt_reg.zfill) ? pad : '0;
        e_sign_end_next = e_lead_end_next + CNT_W'(b_fmt_reg.has_sign);
        e_pre_end_next  = e_sign_end_next + CNT_W'(b_fmt_reg.pre_len);
        e_zero_end_next = e_pre_end_next + (b_fmt_reg.zfill ? pad : '0);
        e_dig_end_next  = e_zero_end_next + CNT_W'(b_ndig_reg);
        e_last_next     = e_dig_end_next + (b_fmt_reg.left ? pad : '0) - 1'b1;
    end

    // emitter control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_busy_reg <= 1'b0;
            e_pos_reg  <= '0;
        end
        else if (emit_take)
        begin
            e_busy_reg <= b_vld_reg;
            e_pos_reg  <= '0;
        end
        else if (m_axis_tready)
        begin
            e_pos_reg <= e_pos_reg + 1'b1;
        end
    end

    // emitter field layout
    always_ff @(posedge clk)
    begin
        if (emit_take)
        begin
            e_lead_end_reg <= e_lead_end_next;
            e_sign_end_reg <= e_sign_end_next;
            e_pre_end_reg  <= e_pre_end_next;
            e_zero_end_reg <= e_zero_end_next;
            e_dig_end_reg  <= e_dig_end_next;
            e_last_reg     <= e_last_next;
            e_sign_ch_reg  <= b_fmt_reg.sign_ch;
            e_upper_reg    <= b_fmt_reg.upper;
            e_dig_reg      <= b_dig_reg;
        end
    end

    // character at the current position
    assign e_idx = e_dig_end_reg - 1'b1 - e_pos_reg;

    always_comb
    begin
        if (e_pos_reg < e_lead_end_reg)
            m_axis_tdata = CH_SPACE;
        else if (e_pos_reg < e_sign_end_reg)
            m_axis_tdata = e_sign_ch_reg;
        else if (e_pos_reg < e_pre_end_reg)
            m_axis_tdata = (e_pos_reg == e_sign_end_reg) ? CH_ZERO :
                           (e_upper_reg ? CH_UPPER_X : CH_LOWER_X);
        else if (e_pos_reg < e_zero_end_reg)
            m_axis_tdata = CH_ZERO;
        else if (e_pos_reg < e_dig_end_reg)
            m_axis_tdata = (e_idx < CNT_W'(NDMAX)) ?
                           digit_char(e_dig_reg[e_idx[DIW-1:0]], e_upper_reg) : CH_ZERO;
        else
            m_axis_tdata = CH_SPACE;
    end

    assign m_axis_tvalid = e_busy_reg;
    assign m_axis_tlast  = e_at_last;

endmodule

/* rtl/ifmt_checker.sv */
`timescale 1ns / 1ps
// checker: port-level properties of the field formatter, bound to the top level
module ifmt_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ifmt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import ifmt_pkg::*;

    // a stalled character holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed under stall");

    // only printable field characters come out
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata >= CH_SPACE) && (m_axis_tdata <= CH_LOWER_X))
    else $error("character outside field alphabet");

    // a field never ends on a minus or plus sign or on the x of a hex prefix
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata != CH_MINUS && m_axis_tdata != CH_PLUS &&
            m_axis_tdata != CH_LOWER_X && m_axis_tdata != CH_UPPER_X)
    else $error("field ends before its digits");

endmodule

bind integer_field_formatter_unit ifmt_checker u_ifmt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/tb_integer_field_formatter_unit.sv */
`timescale 1ns / 1ps
// testbench: integer field formatter, directed and random conversions checked char by char
module tb_integer_field_formatter_unit;
    import ifmt_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    typedef struct {
        logic [2:0] cmd;
        logic [31:0] value;
        logic [5:0] wid;
        logic has_prec;
        logic [5:0] prec;
        logic left;
        logic alt;
        logic plus;
        logic space;
        logic zero;
    } conv_t;

    typedef struct {
        logic [7:0] ch;
        logic last;
    } char_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    char_t expected_chars[$];
    int errors;
    int n_items;
    int n_chars;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;

    integer_field_formatter_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout at %0t", $time);
            $display("integer_field_formatter_unit: mismatch");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        char_t exp_c;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_chars++;
            if (expected_chars.size() == 0)
            begin
                $display("%0t unexpected char: actual %h last %b", $time, m_axis_tdata,
                    m_axis_tlast);
                errors++;
            end
            else
            begin
                exp_c = expected_chars.pop_front();
                if (m_axis_tdata !== exp_c.ch || m_axis_tlast !== exp_c.last)
                begin
                    $display("%0t char mismatch: expected %h last %b, actual %h last %b",
                        $time, exp_c.ch, exp_c.last, m_axis_tdata, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // predict the formatted field of one conversion
    task automatic format_field(input conv_t c);
        logic [7:0] out_q[$];
        logic [7:0] digs[$];
        logic [31:0] mag;
        logic [7:0] sign_ch;
        logic [4:0] base;
        logic upper;
        logic alt;
        logic [3:0] d;
        int wid;
        int prec;
        int min_d;
        int pre_len;
        int pad;
        char_t e;
        if (c.cmd > CMD_PTR)
            return;
        wid = (c.wid > 63) ? 63 : c.wid;
        prec = (c.prec > 60) ? 60 : c.prec;
        base = (c.cmd == CMD_OCT) ? 5'd8 : (c.cmd >= CMD_HEXL) ? 5'd16 : 5'd10;
        upper = (c.cmd == CMD_HEXU);
        alt = c.alt || (c.cmd == CMD_PTR);
        mag = c.value;
        sign_ch = 8'h00;
        if (c.cmd == CMD_SDEC)
        begin
            if (mag[31])
            begin
                sign_ch = CH_MINUS;
                mag = -mag;
            end
            else if (c.plus)
                sign_ch = CH_PLUS;
            else if (c.space)
                sign_ch = CH_SPACE;
        end
        pre_len = 0;
        if (alt && mag != 0)
            pre_len = (base == 8) ? 1 : (base == 16) ? 2 : 0;
        min_d = c.has_prec ? prec : 1;
        if (min_d < 1)
            min_d = 1;
        do
        begin
            d = 4'(mag % base);
            digs.push_front(d > 9 ? 8'(d) - 8'd10 + (upper ? CH_UPPER_A : CH_LOWER_A)
                                  : 8'(d) + CH_ZERO);
            mag = mag / base;
        end
        while (digs.size() < 64 && (digs.size() < min_d || mag != 0));
        pad = wid - (digs.size() + pre_len + (sign_ch != 0 ? 1 : 0));
        if (!c.left && !(c.zero && !c.has_prec))
            for (int i = 0; i < pad; i++)
                out_q.push_back(CH_SPACE);
        if (sign_ch != 0)
            out_q.push_back(sign_ch);
        if (pre_len >= 1)
            out_q.push_back(CH_ZERO);
        if (pre_len == 2)
            out_q.push_back(upper ? CH_UPPER_X : CH_LOWER_X);
        if (!c.left && c.zero && !c.has_prec)
            for (int i = 0; i < pad; i++)
                out_q.push_back(CH_ZERO);
        foreach (digs[i])
            out_q.push_back(digs[i]);
        if (c.left)
            for (int i = 0; i < pad; i++)
                out_q.push_back(CH_SPACE);
        foreach (out_q[i])
        begin
            if (i < 64)
            begin
                e.ch = out_q[i];
                e.last = (i == out_q.size() - 1) || (i == 63);
                expected_chars.push_back(e);
            end
        end
    endtask

    // send one conversion item
    task automatic send_conv(input conv_t c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        format_field(c);
        s_axis_tdata <= {3'd0, c.zero, c.space, c.plus, c.alt, c.left, c.prec, c.has_prec,
                         c.wid, c.value, c.cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_items++;
    endtask

    function automatic conv_t plain(input logic [2:0] cmd, input logic [31:0] value);
        conv_t c;
        c = '{cmd: cmd, value: value, wid: 6'd0, has_prec: 1'b0, prec: 6'd0, left: 1'b0,
              alt: 1'b0, plus: 1'b0, space: 1'b0, zero: 1'b0};
        return c;
    endfunction

    function automatic conv_t rand_conv();
        conv_t c;
        int r;
        c.cmd = 3'($urandom_range(7));
        if (c.cmd > CMD_PTR && $urandom_range(3) != 0)
            c.cmd = 3'($urandom_range(5));
        r = $urandom_range(5);
        c.value = (r == 0) ? 32'($urandom_range(20)) : (r == 1) ? -32'($urandom_range(20))
                : (r == 2) ? {1'($urandom_range(1)), 31'd0} : 32'($urandom);
        c.wid = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(16));
        c.has_prec = 1'($urandom_range(1));
        c.prec = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(12));
        c.left = 1'($urandom_range(1));
        c.alt = 1'($urandom_range(1));
        c.plus = 1'($urandom_range(1));
        c.space = 1'($urandom_range(1));
        c.zero = 1'($urandom_range(1));
        return c;
    endfunction

    // wait until every expected char has arrived, then pipeline drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_directed();
        conv_t c;
        for (int k = 0; k <= 7; k++)
            send_conv(plain(3'(k), 32'hdeadbeef));
        send_conv(plain(CMD_SDEC, 32'h80000000));
        send_conv(plain(CMD_UDEC, 32'hffffffff));
        c = plain(CMD_OCT, 32'd0);
        c.has_prec = 1'b1;
        c.alt = 1'b1;
        send_conv(c);
        c = plain(CMD_UDEC, 32'd5);
        c.alt = 1'b1;
        c.plus = 1'b1;
        c.space = 1'b1;
        send_conv(c);
        c = plain(CMD_SDEC, 32'd42);
        c.space = 1'b1;
        c.zero = 1'b1;
        c.wid = 6'd63;
        send_conv(c);
        c = plain(CMD_HEXU, 32'hab);
        c.alt = 1'b1;
        c.zero = 1'b1;
        c.wid = 6'd12;
        c.has_prec = 1'b1;
        c.prec = 6'd4;
        send_conv(c);
        c = plain(CMD_PTR, 32'h1f);
        c.left = 1'b1;
        c.zero = 1'b1;
        c.wid = 6'd20;
        send_conv(c);
        c = plain(CMD_SDEC, 32'hffffffff);
        c.has_prec = 1'b1;
        c.prec = 6'd63;
        c.wid = 6'd63;
        send_conv(c);
        c = plain(CMD_HEXL, 32'hffffffff);
        c.has_prec = 1'b1;
        c.prec = 6'd60;
        c.alt = 1'b1;
        c.plus = 1'b1;
        send_conv(c);
        c = plain(CMD_OCT, 32'o777);
        c.wid = 6'd2;
        c.alt = 1'b1;
        send_conv(c);
        drain();
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            send_conv(rand_conv());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        errors = 0;
        n_items = 0;
        n_chars = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(100, 0, 0);
        test_random(70, 74, 0);
        test_random(70, 0, 74);
        test_random(110, 38, 38);
        $display("%0d conversions sent, %0d chars checked, all kinds with idle and stall",
            n_items, n_chars);
        if (errors == 0)
            $display("integer_field_formatter_unit: match");
        else
            $display("integer_field_formatter_unit: mismatch");
        $finish;
    end

endmodule
